// ===== rtl/tabl_pkg.sv =====
// Package for the three-axis biquad lowpass: widths, fixed-point formats,
// register map, sequencer states and the coefficient bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tabl_pkg;

    // Item format
    localparam int AXES           = 3;
    localparam int AXIS_W         = $clog2(AXES);
    localparam int SAMPLE_BITS    = 16;

    // Fixed-point formats
    localparam int COEF_BITS      = 24;
    localparam int COEF_FRAC_BITS = 20;
    localparam int STATE_BITS     = 32;
    localparam int STATE_FRAC     = 8;
    localparam int SCALE_FRAC     = 16;

    // Shared multiplier: state sum (34 bits) times a coefficient widened to 25 bits
    localparam int SUM_BITS       = STATE_BITS + 2;
    localparam int MUL_B_BITS     = COEF_BITS + 1;
    localparam int PROD_BITS      = SUM_BITS + MUL_B_BITS;

    // Configuration port
    localparam int APB_ADDR_BITS  = 4;
    localparam int APB_DATA_BITS  = 32;

    typedef enum logic [1:0] {
        REG_FB_ONE  = 2'd0,
        REG_FB_TWO  = 2'd1,
        REG_FWD_ZERO = 2'd2,
        REG_SCALE   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] fb_one;
        logic signed [COEF_BITS-1:0] fb_two;
        logic signed [COEF_BITS-1:0] fwd_zero;
        logic        [COEF_BITS-1:0] scale;
    } t_coefs;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_MUL1,
        S_MUL2,
        S_W0,
        S_SUM,
        S_MUL3,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/tabl_ifs.sv =====
// Valid/ready channel interfaces for sample requests and filtered results.
// Depends on tabl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tabl_in_if import tabl_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;

    modport source (output valid, func, sample_x, sample_y, sample_z, input ready);
    modport sink   (input valid, func, sample_x, sample_y, sample_z, output ready);
endinterface

interface tabl_out_if import tabl_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] filtered_x;
    logic signed [SAMPLE_BITS-1:0] filtered_y;
    logic signed [SAMPLE_BITS-1:0] filtered_z;
    logic        [AXES-1:0]        overflow_flags;

    modport source (output valid, filtered_x, filtered_y, filtered_z, overflow_flags,
                    input ready);
    modport sink   (input valid, filtered_x, filtered_y, filtered_z, overflow_flags,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/tabl_apb_regs.sv =====
// APB-style coefficient register file for the biquad lowpass.
// Depends on tabl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tabl_apb_regs import tabl_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_coefs                   o_coefs
);

    t_coefs   r_coefs;
    t_reg_idx s_idx;
    logic     s_wr;

    assign s_idx  = t_reg_idx'(paddr[APB_ADDR_BITS-1:2]);
    assign s_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (s_wr) begin
            case (s_idx)
                REG_FB_ONE:   r_coefs.fb_one   <= pwdata[COEF_BITS-1:0];
                REG_FB_TWO:   r_coefs.fb_two   <= pwdata[COEF_BITS-1:0];
                REG_FWD_ZERO: r_coefs.fwd_zero <= pwdata[COEF_BITS-1:0];
                REG_SCALE:    r_coefs.scale    <= pwdata[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Readback, raw register bits
    always_comb begin
        case (s_idx)
            REG_FB_ONE:   prdata = APB_DATA_BITS'(unsigned'(r_coefs.fb_one));
            REG_FB_TWO:   prdata = APB_DATA_BITS'(unsigned'(r_coefs.fb_two));
            REG_FWD_ZERO: prdata = APB_DATA_BITS'(unsigned'(r_coefs.fwd_zero));
            REG_SCALE:    prdata = APB_DATA_BITS'(r_coefs.scale);
            default:      prdata = '0;
        endcase
    end

    assign o_coefs = r_coefs;

endmodule

`default_nettype wire

// ===== rtl/three_axis_biquad_lowpass.sv =====
// Three-axis second-order lowpass (direct form II) with delay state in a
// small synchronous memory and one shared multiplier.
// Depends on tabl_pkg, tabl_ifs (tabl_in_if, tabl_out_if) and tabl_apb_regs.
//
// Usage:
//  - i_in carries one request: func (1 = prime the delay elements from the
//    sample first) and one signed 16-bit sample per axis. It is accepted when
//    valid and ready are high; ready is high only while no request is in work.
//  - o_out carries the saturated outputs and a per-axis overflow flag. The
//    result sits in an output register until taken, and the next request may
//    be accepted while it waits.
//  - Each axis goes through memory read, load, two feedback products,
//    rounding of w0, the forward sum, the forward product and output rounding,
//    all through one 34x25 multiplier. A new request is taken only once all
//    three axes are through and their result is in the output register.
//  - If the previous result is still held at the end of a request, the
//    sequencer waits in its last step until the output register frees.
//  - The user writes coefficients via APB only while idle; the block does not enforce it.
//  - Reset (synchronous, active low) clears coefficients, empties the output
//    register and marks all delay entries as zero through per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module three_axis_biquad_lowpass import tabl_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    tabl_in_if.sink                  i_in,
    tabl_out_if.source               o_out,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int MEM_BITS = 2 * STATE_BITS;

    // Saturate a wide product-format value to the signed state range
    function automatic logic signed [STATE_BITS-1:0] f_sat_state(
        input logic signed [PROD_BITS-1:0] v
    );
        logic fits;
        fits = (v[PROD_BITS-1:STATE_BITS-1] == {(PROD_BITS-STATE_BITS+1){v[STATE_BITS-1]}});
        if (fits)
            return v[STATE_BITS-1:0];
        else if (v[PROD_BITS-1])
            return {1'b1, {(STATE_BITS-1){1'b0}}};
        else
            return {1'b0, {(STATE_BITS-1){1'b1}}};
    endfunction

    // Saturate to the signed sample range
    function automatic logic signed [SAMPLE_BITS-1:0] f_sat_sample(
        input logic signed [PROD_BITS-1:0] v
    );
        logic fits;
        fits = (v[PROD_BITS-1:SAMPLE_BITS-1] ==
                {(PROD_BITS-SAMPLE_BITS+1){v[SAMPLE_BITS-1]}});
        if (fits)
            return v[SAMPLE_BITS-1:0];
        else if (v[PROD_BITS-1])
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

    t_coefs s_coefs;

    t_state r_state, n_state;
    logic [AXIS_W-1:0] r_axis;

    // Request and working registers
    logic                          r_func;
    logic signed [SAMPLE_BITS-1:0] r_x [AXES];
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [PROD_BITS-1:0]   r_acc;
    logic signed [STATE_BITS-1:0]  r_w0, r_w1, r_w2;
    logic signed [SUM_BITS-1:0]    r_sum;
    logic        [AXES-1:0]        r_flags;
    logic signed [SAMPLE_BITS-1:0] r_y [AXES];

    // Delay memory: entry per axis holds {w2, w1}
    logic [MEM_BITS-1:0] r_mem [AXES];
    logic [MEM_BITS-1:0] r_rd_data;
    logic                r_rd_vld;
    logic [AXES-1:0]     r_vld;

    // Output register
    logic                          r_out_vld;
    logic signed [SAMPLE_BITS-1:0] r_out_y [AXES];
    logic        [AXES-1:0]        r_out_flags;

    // Control
    logic s_in_ready, s_in_acc, s_rd_en, s_wr_en, s_last, s_out_free, s_load_out;

    // Datapath
    logic signed [SAMPLE_BITS-1:0] s_x;
    logic signed [SUM_BITS-1:0]    s_mul_a;
    logic signed [MUL_B_BITS-1:0]  s_mul_b;
    logic signed [PROD_BITS-1:0]   s_mul;
    logic signed [PROD_BITS-1:0]   s_prime_shf;
    logic signed [STATE_BITS-1:0]  s_prime;
    logic signed [PROD_BITS-1:0]   s_xacc;
    logic signed [PROD_BITS-1:0]   s_w0_acc;
    logic signed [PROD_BITS-1:0]   s_w0_shf;
    logic                          s_w0_ovf;
    logic signed [STATE_BITS-1:0]  s_xq;
    logic signed [PROD_BITS-1:0]   s_y_shf;
    logic signed [SAMPLE_BITS-1:0] s_y;

    tabl_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (s_coefs)
    );

    // Sequencer outputs
    always_comb begin
        s_last     = (r_axis == AXIS_W'(AXES - 1));
        s_out_free = !r_out_vld || o_out.ready;
        s_in_ready = (r_state == S_IDLE);
        s_rd_en    = (r_state == S_READ);
        s_wr_en    = (r_state == S_MUL3);
        s_load_out = (r_state == S_OUT) && s_last && s_out_free;
    end

    assign i_in.ready = s_in_ready;
    assign s_in_acc   = i_in.valid && s_in_ready;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_READ;
            S_READ:  n_state = S_LOAD;
            S_LOAD:  n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_W0;
            S_W0:    n_state = S_SUM;
            S_SUM:   n_state = S_MUL3;
            S_MUL3:  n_state = S_OUT;
            S_OUT: begin
                if (!s_last)
                    n_state = S_READ;
                else if (s_out_free)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_axis    <= '0;
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_in_acc)
                r_axis <= '0;
            else if (r_state == S_OUT && !s_last)
                r_axis <= r_axis + AXIS_W'(1);
            if (s_wr_en)
                r_vld[r_axis] <= 1'b1;
            if (s_rd_en)
                r_rd_vld <= r_vld[r_axis];
            if (s_load_out)
                r_out_vld <= 1'b1;
            else if (o_out.ready)
                r_out_vld <= 1'b0;
        end
    end

    // Delay memory; a write and a read never fall in the same cycle
    always_ff @(posedge i_clk) begin
        if (s_wr_en)
            r_mem[r_axis] <= {r_w1, r_w0};
        if (s_rd_en)
            r_rd_data <= r_mem[r_axis];
    end

    assign s_x = r_x[r_axis];

    // Shared multiplier operand select
    always_comb begin
        case (r_state)
            S_READ: begin
                s_mul_a = SUM_BITS'(s_x);
                s_mul_b = signed'({1'b0, s_coefs.scale});
            end
            S_MUL1: begin
                s_mul_a = SUM_BITS'(r_w1);
                s_mul_b = MUL_B_BITS'(s_coefs.fb_one);
            end
            S_MUL2: begin
                s_mul_a = SUM_BITS'(r_w2);
                s_mul_b = MUL_B_BITS'(s_coefs.fb_two);
            end
            default: begin
                s_mul_a = r_sum;
                s_mul_b = MUL_B_BITS'(s_coefs.fwd_zero);
            end
        endcase
    end

    assign s_mul = s_mul_a * s_mul_b;

    // Prime value: x * scale rounded to Q.8, saturated
    assign s_prime_shf = (r_prod + (PROD_BITS'(1) <<< (SCALE_FRAC - STATE_FRAC - 1)))
                         >>> (SCALE_FRAC - STATE_FRAC);
    assign s_prime     = f_sat_state(s_prime_shf);

    // w0: sample term minus feedback, rounded; out of range falls back to the sample
    assign s_xacc   = PROD_BITS'(s_x) <<< (STATE_FRAC + COEF_FRAC_BITS);
    assign s_w0_acc = r_acc - r_prod;
    assign s_w0_shf = (s_w0_acc + (PROD_BITS'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    assign s_w0_ovf = (s_w0_shf[PROD_BITS-1:STATE_BITS-1] !=
                       {(PROD_BITS-STATE_BITS+1){s_w0_shf[STATE_BITS-1]}});
    assign s_xq     = STATE_BITS'(s_x) <<< STATE_FRAC;

    // Output: forward product rounded back to sample scale
    assign s_y_shf = (r_prod + (PROD_BITS'(1) <<< (COEF_FRAC_BITS + STATE_FRAC - 1)))
                     >>> (COEF_FRAC_BITS + STATE_FRAC);
    assign s_y     = f_sat_sample(s_y_shf);

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (s_in_acc) begin
            r_func <= i_in.func;
            r_x[0] <= i_in.sample_x;
            r_x[1] <= i_in.sample_y;
            r_x[2] <= i_in.sample_z;
        end
        case (r_state)
            S_READ, S_MUL1, S_MUL3: r_prod <= s_mul;
            S_LOAD: begin
                if (r_func) begin
                    r_w1 <= s_prime;
                    r_w2 <= s_prime;
                end else if (r_rd_vld) begin
                    r_w1 <= r_rd_data[STATE_BITS-1:0];
                    r_w2 <= r_rd_data[MEM_BITS-1:STATE_BITS];
                end else begin
                    r_w1 <= '0;
                    r_w2 <= '0;
                end
            end
            S_MUL2: begin
                r_acc  <= s_xacc - r_prod;
                r_prod <= s_mul;
            end
            S_W0: begin
                r_w0           <= s_w0_ovf ? s_xq : s_w0_shf[STATE_BITS-1:0];
                r_flags[r_axis] <= s_w0_ovf;
            end
            S_SUM: r_sum <= SUM_BITS'(r_w0) + (SUM_BITS'(r_w1) <<< 1) + SUM_BITS'(r_w2);
            S_OUT: begin
                if (!s_last)
                    r_y[r_axis] <= s_y;
            end
            default: ;
        endcase
        // Load the output register, last axis straight from rounding
        if (s_load_out) begin
            for (int i = 0; i < AXES; i++)
                r_out_y[i] <= (i == AXES - 1) ? s_y : r_y[i];
            r_out_flags <= r_flags;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.filtered_x     = r_out_y[0];
    assign o_out.filtered_y     = r_out_y[1];
    assign o_out.filtered_z     = r_out_y[2];
    assign o_out.overflow_flags = r_out_flags;

`ifndef SYNTHESIS
    // Output register is only loaded when it is free or being drained
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_load_out |-> (!r_out_vld || o_out.ready))
        else $error("result loaded over a held result");

    // An accepted request starts with a read of the first axis
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_acc |=> (r_state == S_READ && r_axis == '0))
        else $error("request did not start at first axis");

    // Axis counter stays within the memory
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis <= AXIS_W'(AXES - 1))
        else $error("axis counter out of range");

    // Write-back follows the forward sum, for the same axis
    a_wb_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_wr_en |-> ($past(r_state) == S_SUM && $stable(r_axis)))
        else $error("write-back out of sequence");
`endif

endmodule

`default_nettype wire
